// ===== sv/smtt_pkg.sv =====
// Shared types and constants for the software-managed translation table.
// Holds request/response payloads, entry layout, command codes and the FSM states.
// No dependencies.
`default_nettype none

package smtt_pkg;

	localparam int VPN_BITS        = 20;
	localparam int FRAME_BITS      = 20;
	localparam int PROT_BITS       = 3;
	localparam int FUNC_BITS       = 3;
	localparam int HIT_BITS        = 4;
	localparam int CFG_BITS        = 5;
	// Scan counter: wide enough to hold the largest active count (16)
	localparam int CNT_W           = 5;
	localparam int DEFAULT_ENTRIES = 16;
	localparam int MAX_ACTIVE      = 16;

	localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(16);

	// Command codes
	localparam logic [FUNC_BITS-1:0] FN_LOOKUP = 3'd0;
	localparam logic [FUNC_BITS-1:0] FN_WRITE  = 3'd1;
	localparam logic [FUNC_BITS-1:0] FN_UNMAP  = 3'd2;
	localparam logic [FUNC_BITS-1:0] FN_READ   = 3'd3;
	localparam logic [FUNC_BITS-1:0] FN_FLUSH  = 3'd4;
	localparam logic [FUNC_BITS-1:0] FN_SYNC   = 3'd5;

	// Result kinds
	localparam logic KIND_ANSWER = 1'b0;
	localparam logic KIND_WB     = 1'b1;

	// Protection bit that makes a page dirty-capable
	localparam int PROT_WRITE_BIT = 1;

	typedef struct packed {
		logic [FUNC_BITS-1:0]  func;
		logic [HIT_BITS-1:0]   entry_index;
		logic [VPN_BITS-1:0]   vpn;
		logic [FRAME_BITS-1:0] frame;
		logic [PROT_BITS-1:0]  prot;
	} req_t;

	typedef struct packed {
		logic                  kind;
		logic                  ok;
		logic [HIT_BITS-1:0]   hit_index;
		logic [VPN_BITS-1:0]   out_vpn;
		logic [FRAME_BITS-1:0] out_frame;
		logic [PROT_BITS-1:0]  out_prot;
		logic                  last;
	} rsp_t;

	typedef struct packed {
		logic [VPN_BITS-1:0]   vpn;
		logic [FRAME_BITS-1:0] frame;
		logic [PROT_BITS-1:0]  prot;
	} entry_t;

	// Verdict of the shared compare unit for one entry
	typedef struct packed {
		logic hit;
		logic evict;
		logic wb;
		logic wr;
	} match_t;

	// Store operation issued by the sequencer
	typedef struct packed {
		logic clr;
		logic wr;
	} store_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ANSWER
	} state_t;

endpackage

`default_nettype wire

// ===== sv/smtt_store.sv =====
// Entry store: one flop row per entry plus a valid bit cleared by reset.
// Depends on smtt_pkg for the entry layout and store operation struct.
`default_nettype none

module smtt_store #(
	parameter int DEPTH = smtt_pkg::DEFAULT_ENTRIES,
	parameter int IDX_W = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [IDX_W-1:0]    idx,
	input  wire smtt_pkg::store_op_t op,
	input  wire smtt_pkg::entry_t    wdata,
	output      smtt_pkg::entry_t    rdata
);

	smtt_pkg::entry_t mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;

	// An entry never written since reset, or evicted, reads as all zero
	assign rdata = valid_q[idx] ? mem_q[idx] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (op.wr) begin
			valid_q[idx] <= 1'b1;
		end else if (op.clr) begin
			valid_q[idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op.wr) begin
			mem_q[idx] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ===== sv/smtt_match.sv =====
// Shared compare unit: judges one entry against the current command.
// Depends on smtt_pkg for command codes and the verdict struct.
`default_nettype none

module smtt_match (
	input  wire logic [smtt_pkg::FUNC_BITS-1:0] func,
	input  wire logic [smtt_pkg::VPN_BITS-1:0]  vpn,
	input  wire smtt_pkg::entry_t               entry,
	output      smtt_pkg::match_t               verdict
);

	logic used;
	logic vmatch;
	logic dirty_ok;

	assign used     = (entry.frame != '0);
	assign vmatch   = (entry.vpn == vpn);
	assign dirty_ok = entry.prot[smtt_pkg::PROT_WRITE_BIT];

	always_comb begin
		verdict = '0;
		unique case (func)
			smtt_pkg::FN_LOOKUP: begin
				verdict.hit = used & vmatch;
			end
			smtt_pkg::FN_WRITE: begin
				verdict.evict = used;
				verdict.wb    = used & dirty_ok;
				verdict.wr    = 1'b1;
			end
			smtt_pkg::FN_UNMAP: begin
				verdict.evict = used & vmatch;
				verdict.wb    = used & vmatch & dirty_ok;
			end
			smtt_pkg::FN_FLUSH: begin
				verdict.evict = used;
				verdict.wb    = used & dirty_ok;
			end
			smtt_pkg::FN_SYNC: begin
				verdict.wb = used & dirty_ok;
			end
			default: begin
				verdict = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/smtt_seq.sv =====
// Sequencer: command decode, entry walk, config register and output register.
// Depends on smtt_pkg; drives smtt_store and reads the smtt_match verdict.
`default_nettype none

module smtt_seq #(
	parameter int DEPTH = smtt_pkg::DEFAULT_ENTRIES,
	parameter int IDX_W = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic [smtt_pkg::CFG_BITS-1:0] cfg_data,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire smtt_pkg::req_t                in_data,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      smtt_pkg::rsp_t                out_data,
	output      smtt_pkg::req_t                cmd,
	input  wire smtt_pkg::match_t              verdict,
	output      logic [IDX_W-1:0]              st_idx,
	output      smtt_pkg::store_op_t           st_op,
	output      smtt_pkg::entry_t              st_wdata,
	input  wire smtt_pkg::entry_t              st_rdata
);

	localparam logic [smtt_pkg::CNT_W-1:0] DEPTH_CNT = smtt_pkg::CNT_W'(DEPTH);

	smtt_pkg::state_t              state_q, state_d;
	smtt_pkg::req_t                cmd_q;
	smtt_pkg::rsp_t                ans_q, ans_d;
	smtt_pkg::rsp_t                out_q, out_d;
	logic                          out_valid_q;
	logic                          out_load;
	logic                          cmd_load;
	logic                          slot_free;
	logic [smtt_pkg::CFG_BITS-1:0] entries_q;
	logic [smtt_pkg::CNT_W-1:0]    n_active;
	logic [smtt_pkg::CNT_W-1:0]    i_q, i_d;
	logic [smtt_pkg::CNT_W-1:0]    lim_q, lim_d;
	logic                          idx_ok;

	assign cfg_ready = 1'b1;
	assign n_active  = (entries_q > DEPTH_CNT) ? DEPTH_CNT : entries_q;
	assign idx_ok    = ({1'b0, in_data.entry_index} < n_active);
	assign slot_free = !out_valid_q || out_ready;

	assign cmd       = cmd_q;
	assign st_idx    = i_q[IDX_W-1:0];
	assign st_wdata  = '{vpn: cmd_q.vpn, frame: cmd_q.frame, prot: cmd_q.prot};
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smtt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd_load = 1'b0;
		out_load = 1'b0;
		out_d    = ans_q;
		ans_d    = ans_q;
		i_d      = i_q;
		lim_d    = lim_q;
		st_op    = '0;
		unique case (state_q)
			smtt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd_load   = 1'b1;
					ans_d      = '0;
					ans_d.kind = smtt_pkg::KIND_ANSWER;
					ans_d.last = 1'b1;
					i_d        = '0;
					lim_d      = n_active;
					unique case (in_data.func)
						smtt_pkg::FN_LOOKUP: begin
							state_d = smtt_pkg::ST_SCAN;
						end
						smtt_pkg::FN_WRITE, smtt_pkg::FN_READ: begin
							ans_d.hit_index = in_data.entry_index;
							if (idx_ok) begin
								ans_d.ok = 1'b1;
								i_d      = {1'b0, in_data.entry_index};
								lim_d    = {1'b0, in_data.entry_index} + smtt_pkg::CNT_W'(1);
								state_d  = smtt_pkg::ST_SCAN;
							end else begin
								state_d = smtt_pkg::ST_ANSWER;
							end
						end
						smtt_pkg::FN_UNMAP, smtt_pkg::FN_FLUSH, smtt_pkg::FN_SYNC: begin
							ans_d.ok = 1'b1;
							state_d  = smtt_pkg::ST_SCAN;
						end
						default: begin
							state_d = smtt_pkg::ST_ANSWER;
						end
					endcase
				end
			end
			smtt_pkg::ST_SCAN: begin
				if (i_q >= lim_q) begin
					state_d = smtt_pkg::ST_ANSWER;
				end else if (!verdict.wb || slot_free) begin
					// hold the walk while a write-back waits for the output slot
					st_op.clr = verdict.evict;
					st_op.wr  = verdict.wr;
					i_d       = i_q + smtt_pkg::CNT_W'(1);
					if (verdict.wb) begin
						out_load        = 1'b1;
						out_d.kind      = smtt_pkg::KIND_WB;
						out_d.ok        = 1'b1;
						out_d.hit_index = i_q[smtt_pkg::HIT_BITS-1:0];
						out_d.out_vpn   = st_rdata.vpn;
						out_d.out_frame = st_rdata.frame;
						out_d.out_prot  = st_rdata.prot;
						out_d.last      = 1'b0;
					end
					if (cmd_q.func == smtt_pkg::FN_READ) begin
						ans_d.out_vpn   = st_rdata.vpn;
						ans_d.out_frame = st_rdata.frame;
						ans_d.out_prot  = st_rdata.prot;
					end
					if (verdict.hit) begin
						ans_d.ok        = 1'b1;
						ans_d.hit_index = i_q[smtt_pkg::HIT_BITS-1:0];
						state_d         = smtt_pkg::ST_ANSWER;
					end
				end
			end
			smtt_pkg::ST_ANSWER: begin
				if (slot_free) begin
					out_load = 1'b1;
					out_d    = ans_q;
					state_d  = smtt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = smtt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			entries_q   <= smtt_pkg::CFG_RESET;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				entries_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_load) begin
			cmd_q <= in_data;
		end
		if (out_load) begin
			out_q <= out_d;
		end
		ans_q <= ans_d;
		i_q   <= i_d;
		lim_q <= lim_d;
	end

endmodule

`default_nettype wire

// ===== sv/soft_managed_tlb_table_core.sv =====
// Software-managed fully associative translation table: block top level.
// Channels:  in_* carries one command request (lookup, write, unmap, read, flush,
//   sync); out_* returns zero or more write-back requests followed by exactly one
//   command answer (last=1); cfg_* writes entries_in_use and is always ready; the
//   user must write it only while the block is idle, which the block does not enforce.
// Timing: a command is taken only when the block is idle (in_ready high). Scans
//   visit one entry per cycle through a single comparator, except while a
//   write-back waits for the output register. Lookup, unmap, flush and sync walk
//   the active entries (entries_in_use, capped at the table depth of at most
//   sixteen); write and read visit only the addressed entry, and a bad index or a
//   bad func is answered without a walk. A lookup stops at its first hit. in_ready
//   returns the cycle after the answer is loaded, so no new command is taken before the previous one is answered.
// Back-pressure: results sit in one output register. A write-back that finds the
//   register full holds the walk at that entry until the receiver takes the
//   previous request; the answer waits the same way. A new command may be
//   accepted while the final answer is still waiting in the output register.
// Reset: arst_n clears every valid bit, so all entries read as unused, and sets
//   entries_in_use to 16. No clearing pass is needed.
// Depends on smtt_pkg, smtt_store, smtt_match and smtt_seq.
`default_nettype none

module soft_managed_tlb_table_core #(
	parameter int ENTRIES = smtt_pkg::DEFAULT_ENTRIES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic [smtt_pkg::CFG_BITS-1:0] cfg_data,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire smtt_pkg::req_t                in_data,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      smtt_pkg::rsp_t                out_data
);

	// Commands never address beyond sixteen entries, so keep no more rows
	localparam int DEPTH = (ENTRIES < smtt_pkg::MAX_ACTIVE) ? ENTRIES : smtt_pkg::MAX_ACTIVE;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	smtt_pkg::req_t      cmd;
	smtt_pkg::match_t    verdict;
	smtt_pkg::store_op_t st_op;
	smtt_pkg::entry_t    st_wdata;
	smtt_pkg::entry_t    st_rdata;
	logic [IDX_W-1:0]    st_idx;

	// Sequencer: decode, walk the entries, hold the single output slot
	smtt_seq #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cmd       (cmd),
		.verdict   (verdict),
		.st_idx    (st_idx),
		.st_op     (st_op),
		.st_wdata  (st_wdata),
		.st_rdata  (st_rdata)
	);

	// Shared comparator, reused for every entry of a walk
	smtt_match u_match (
		.func    (cmd.func),
		.vpn     (cmd.vpn),
		.entry   (st_rdata),
		.verdict (verdict)
	);

	// Entry rows with reset-cleared valid bits
	smtt_store #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (st_idx),
		.op     (st_op),
		.wdata  (st_wdata),
		.rdata  (st_rdata)
	);

endmodule

`default_nettype wire

// ===== sv/smtt_checker.sv =====
// Port-level checks for the translation table top level, attached by bind.
// Depends on smtt_pkg and soft_managed_tlb_table_core.
`default_nettype none

module smtt_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_ready,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire smtt_pkg::rsp_t out_data
);

	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// Go busy once a command request is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while a command was in progress");

	// Ready returns only together with the command answer
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> out_valid && out_data.last)
		else $error("block went idle without presenting an answer");

	// A write-back always belongs to a command still in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == smtt_pkg::KIND_WB |-> !in_ready && !out_data.last)
		else $error("write-back shown while idle or marked last");

endmodule

bind soft_managed_tlb_table_core smtt_checker u_smtt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire
